// ===== design/bfsa_pkg.sv =====
// Shared types and constants for the bitmap fit-scale address generator.
// No dependencies; imported by bfsa_cfg and bmp_fit_scale_address_generator.
package bfsa_pkg;

    localparam int OFF_W   = 32;
    localparam int SRC_W   = 13;
    localparam int BOXP_W  = 10;
    localparam int BOXS_W  = 11;
    localparam int SCR_W   = 11;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_OFFSET    = 3'd0,
        CFG_SOURCE_WIDTH   = 3'd1,
        CFG_SOURCE_HEIGHT  = 3'd2,
        CFG_ROWS_BOTTOM_UP = 3'd3,
        CFG_BOX_LEFT       = 3'd4,
        CFG_BOX_TOP        = 3'd5,
        CFG_BOX_WIDTH      = 3'd6,
        CFG_BOX_HEIGHT     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [OFF_W-1:0]  data_offset;
        logic [SRC_W-1:0]  source_width;
        logic [SRC_W-1:0]  source_height;
        logic              rows_bottom_up;
        logic [BOXP_W-1:0] box_left;
        logic [BOXP_W-1:0] box_top;
        logic [BOXS_W-1:0] box_width;
        logic [BOXS_W-1:0] box_height;
    } t_cfg;

    localparam logic [OFF_W-1:0]  RST_DATA_OFFSET    = 32'd54;
    localparam logic [SRC_W-1:0]  RST_SOURCE_WIDTH   = 13'd1;
    localparam logic [SRC_W-1:0]  RST_SOURCE_HEIGHT  = 13'd1;
    localparam logic              RST_ROWS_BOTTOM_UP = 1'b1;
    localparam logic [BOXP_W-1:0] RST_BOX_LEFT       = 10'd0;
    localparam logic [BOXP_W-1:0] RST_BOX_TOP        = 10'd0;
    localparam logic [BOXS_W-1:0] RST_BOX_WIDTH      = 11'd240;
    localparam logic [BOXS_W-1:0] RST_BOX_HEIGHT     = 11'd240;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIT_WAIT,
        S_FIT_END,
        S_PIX_GO,
        S_PIX_WAIT,
        S_MUL,
        S_ADD,
        S_EMIT
    } t_state;

endpackage

// ===== design/bfsa_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Stand-alone; no package dependency.
module bfsa_div #(
    parameter int DVD_W = 24,
    parameter int DVS_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_acc;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;

    assign trial = {r_rem, r_acc[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DVD_W);
            r_acc  <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_busy <= (r_cnt != CNT_W'(1));
            r_cnt  <= r_cnt - CNT_W'(1);
            r_acc  <= {r_acc[DVD_W-2:0], ge};
            r_rem  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_acc;

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with zero count");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dvs))
        else $error("partial remainder not below divisor");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not go busy after start");

endmodule

// ===== design/bfsa_cfg.sv =====
// Configuration register file with reset values and indexed write decode.
// Depends on bfsa_pkg for the register struct, index codes and reset values.
module bfsa_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bfsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bfsa_pkg::OFF_W-1:0]     i_cfg_data,
    output bfsa_pkg::t_cfg                 o_regs
);

    import bfsa_pkg::*;

    t_cfg r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.data_offset    <= RST_DATA_OFFSET;
            r_regs.source_width   <= RST_SOURCE_WIDTH;
            r_regs.source_height  <= RST_SOURCE_HEIGHT;
            r_regs.rows_bottom_up <= RST_ROWS_BOTTOM_UP;
            r_regs.box_left       <= RST_BOX_LEFT;
            r_regs.box_top        <= RST_BOX_TOP;
            r_regs.box_width      <= RST_BOX_WIDTH;
            r_regs.box_height     <= RST_BOX_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DATA_OFFSET:    r_regs.data_offset    <= i_cfg_data;
                CFG_SOURCE_WIDTH:   r_regs.source_width   <= i_cfg_data[SRC_W-1:0];
                CFG_SOURCE_HEIGHT:  r_regs.source_height  <= i_cfg_data[SRC_W-1:0];
                CFG_ROWS_BOTTOM_UP: r_regs.rows_bottom_up <= i_cfg_data[0];
                CFG_BOX_LEFT:       r_regs.box_left       <= i_cfg_data[BOXP_W-1:0];
                CFG_BOX_TOP:        r_regs.box_top        <= i_cfg_data[BOXP_W-1:0];
                CFG_BOX_WIDTH:      r_regs.box_width      <= i_cfg_data[BOXS_W-1:0];
                CFG_BOX_HEIGHT:     r_regs.box_height     <= i_cfg_data[BOXS_W-1:0];
            endcase
        end
    end

    assign o_regs = r_regs;

endmodule

// ===== design/bmp_fit_scale_address_generator.sv =====
// Top level of the aspect-fit nearest-neighbor bitmap address generator.
// Depends on bfsa_pkg, bfsa_cfg and two bfsa_div serial dividers.
//
//  channel | direction | handshake                 | beat contents
//  --------+-----------+---------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_start_req
//  out     | output    | o_out_valid / i_out_stall | o_valid_res, o_screen_x, o_screen_y,
//          |           |                           | o_source_offset, o_row_end, o_image_end
//  cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// A pixel beat runs both pixel divisions, then a multiply and an add, to the output register.
// The dividend width of the bit-serial dividers is log2 source dim + log2 box dim, 24 at the
// defaults. A start beat runs both fit divisions first; an idle beat goes straight to output.
// Both source coordinates are divided in parallel on two dividers; one beat is in flight.
// Reset is synchronous and leaves the block finished, waiting for a start beat.
// A stalled output holds the result; the next input beat is taken while it waits.
module bmp_fit_scale_address_generator #(
    parameter int MAX_SOURCE_DIM = 4096,
    parameter int MAX_BOX_DIM    = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_start_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_valid_res,
    output logic [10:0] o_screen_x,
    output logic [10:0] o_screen_y,
    output logic [31:0] o_source_offset,
    output logic        o_row_end,
    output logic        o_image_end,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    import bfsa_pkg::*;

    localparam int SW_W    = $clog2(MAX_SOURCE_DIM + 1);
    localparam int BW_W    = $clog2(MAX_BOX_DIM + 1);
    localparam int DW      = SW_W + BW_W;
    localparam int DV_W    = (SW_W > BW_W) ? SW_W : BW_W;
    localparam int PITCH_W = SW_W + 2;
    localparam int PRD_W   = SW_W + PITCH_W;

    function automatic logic [BW_W-1:0] fit_clamp(input logic [DW-1:0] v,
                                                  input logic [BW_W-1:0] hi);
        logic [BW_W-1:0] res;
        if (v == '0) begin
            res = BW_W'(1);
        end else if (v > DW'(hi)) begin
            res = hi;
        end else begin
            res = BW_W'(v);
        end
        return res;
    endfunction

    t_cfg   cfg;
    t_state r_state, n_state;

    logic               r_finished;
    logic               r_pix;
    logic [BW_W-1:0]    r_col, r_row;
    logic [BW_W-1:0]    r_fit_w, r_fit_h;
    logic [SCR_W-1:0]   r_origin_x, r_origin_y;
    logic [PITCH_W-1:0] r_pitch;
    logic [OFF_W-1:0]   r_term;

    logic               r_out_valid;
    logic               r_valid_res;
    logic [SCR_W-1:0]   r_screen_x, r_screen_y;
    logic [OFF_W-1:0]   r_source_offset;
    logic               r_row_end, r_image_end;

    logic [SW_W-1:0]    sw_c, sh_c;
    logic [BW_W-1:0]    bw_c, bh_c;
    logic               in_acc, out_free, div_go, use_fit;
    logic [DW-1:0]      dvd_a, dvd_b, q_a, q_b;
    logic [DV_W-1:0]    dvs_a, dvs_b;
    logic               busy_a, busy_b;

    logic               fit_gt;
    logic [BW_W-1:0]    ow_n, oh_n, half_x, half_y;
    logic [PITCH_W-1:0] pitch_raw;
    logic [SW_W-1:0]    sxq, syq, syf;
    logic [SW_W+1:0]    sx3;
    logic [PRD_W-1:0]   term_prod;
    logic [BW_W:0]      col_inc, row_inc;
    logic               rend, iend;

    bfsa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_regs      (cfg)
    );

    assign sw_c = (cfg.source_width == '0) ? SW_W'(1) :
                  (32'(cfg.source_width) > MAX_SOURCE_DIM) ? SW_W'(MAX_SOURCE_DIM) :
                  SW_W'(cfg.source_width);
    assign sh_c = (cfg.source_height == '0) ? SW_W'(1) :
                  (32'(cfg.source_height) > MAX_SOURCE_DIM) ? SW_W'(MAX_SOURCE_DIM) :
                  SW_W'(cfg.source_height);
    assign bw_c = (cfg.box_width == '0) ? BW_W'(1) :
                  (32'(cfg.box_width) > MAX_BOX_DIM) ? BW_W'(MAX_BOX_DIM) :
                  BW_W'(cfg.box_width);
    assign bh_c = (cfg.box_height == '0) ? BW_W'(1) :
                  (32'(cfg.box_height) > MAX_BOX_DIM) ? BW_W'(MAX_BOX_DIM) :
                  BW_W'(cfg.box_height);

    // fit divisions in IDLE, pixel divisions otherwise
    assign use_fit = (r_state == S_IDLE);
    assign dvd_a   = use_fit ? DW'(sh_c) * DW'(bw_c) : DW'(r_col) * DW'(sw_c);
    assign dvd_b   = use_fit ? DW'(sw_c) * DW'(bh_c) : DW'(r_row) * DW'(sh_c);
    assign dvs_a   = use_fit ? DV_W'(sw_c) : DV_W'(r_fit_w);
    assign dvs_b   = use_fit ? DV_W'(sh_c) : DV_W'(r_fit_h);

    bfsa_div #(.DVD_W(DW), .DVS_W(DV_W)) u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (dvd_a),
        .i_divisor  (dvs_a),
        .o_busy     (busy_a),
        .o_quotient (q_a)
    );

    bfsa_div #(.DVD_W(DW), .DVS_W(DV_W)) u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_go),
        .i_dividend (dvd_b),
        .i_divisor  (dvs_b),
        .o_busy     (busy_b),
        .o_quotient (q_b)
    );

    assign fit_gt    = (q_a > DW'(bh_c));
    assign ow_n      = fit_clamp(fit_gt ? q_b : DW'(bw_c), bw_c);
    assign oh_n      = fit_clamp(fit_gt ? DW'(bh_c) : q_a, bh_c);
    assign half_x    = (bw_c - ow_n) >> 1;
    assign half_y    = (bh_c - oh_n) >> 1;
    assign pitch_raw = {1'b0, sw_c, 1'b0} + PITCH_W'(sw_c) + PITCH_W'(3);

    assign sxq       = q_a[SW_W-1:0];
    assign syq       = q_b[SW_W-1:0];
    assign syf       = cfg.rows_bottom_up ? (sh_c - SW_W'(1) - syq) : syq;
    assign term_prod = PRD_W'(syf) * PRD_W'(r_pitch);
    assign sx3       = {1'b0, sxq, 1'b0} + (SW_W+2)'(sxq);

    assign col_inc = {1'b0, r_col} + (BW_W+1)'(1);
    assign row_inc = {1'b0, r_row} + (BW_W+1)'(1);
    assign rend    = (col_inc >= {1'b0, r_fit_w});
    assign iend    = rend && (row_inc >= {1'b0, r_fit_h});

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        div_go  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority if (i_start_req) begin
                        div_go  = 1'b1;
                        n_state = S_FIT_WAIT;
                    end else if (r_finished) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_PIX_GO;
                    end
                end
            end
            S_FIT_WAIT: begin
                if (!busy_a && !busy_b) begin
                    n_state = S_FIT_END;
                end
            end
            S_FIT_END: n_state = S_PIX_GO;
            S_PIX_GO: begin
                div_go  = 1'b1;
                n_state = S_PIX_WAIT;
            end
            S_PIX_WAIT: begin
                if (!busy_a && !busy_b) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ADD;
            S_ADD: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finished  <= 1'b1;
            r_pix       <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pix <= 1'b0;
                    end
                end
                S_FIT_END: begin
                    r_fit_w    <= ow_n;
                    r_fit_h    <= oh_n;
                    r_origin_x <= SCR_W'(cfg.box_left) + SCR_W'(half_x);
                    r_origin_y <= SCR_W'(cfg.box_top) + SCR_W'(half_y);
                    r_pitch    <= {pitch_raw[PITCH_W-1:2], 2'b00};
                    r_col      <= '0;
                    r_row      <= '0;
                    r_finished <= 1'b0;
                end
                S_PIX_GO: r_pix <= 1'b1;
                S_MUL:    r_term <= OFF_W'(term_prod);
                S_ADD:    r_term <= r_term + OFF_W'(sx3);
                S_EMIT: begin
                    if (out_free) begin
                        r_valid_res <= r_pix;
                        if (r_pix) begin
                            r_screen_x      <= r_origin_x + SCR_W'(r_col);
                            r_screen_y      <= r_origin_y + SCR_W'(r_row);
                            r_source_offset <= cfg.data_offset + r_term;
                            r_row_end       <= rend;
                            r_image_end     <= iend;
                            if (rend) begin
                                r_col <= '0;
                                r_row <= row_inc[BW_W-1:0];
                                if (iend) begin
                                    r_finished <= 1'b1;
                                end
                            end else begin
                                r_col <= col_inc[BW_W-1:0];
                            end
                        end else begin
                            r_screen_x      <= '0;
                            r_screen_y      <= '0;
                            r_source_offset <= '0;
                            r_row_end       <= 1'b0;
                            r_image_end     <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_valid_res     = r_valid_res;
    assign o_screen_x      = r_screen_x;
    assign o_screen_y      = r_screen_y;
    assign o_source_offset = r_source_offset;
    assign o_row_end       = r_row_end;
    assign o_image_end     = r_image_end;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_finished |-> (r_col < r_fit_w))
        else $error("column cursor beyond fitted width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_finished |-> (r_row < r_fit_h))
        else $error("row cursor beyond fitted height");

    a_fit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_finished |-> ((r_fit_w != '0) && (r_fit_h != '0)))
        else $error("zero fitted size while drawing");

    a_end_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_image_end) |-> (r_row_end && r_valid_res))
        else $error("image end without row end on a pixel");

endmodule

// ===== sim/tb_bmp_fit_scale_address_generator.sv =====
// Testbench for bmp_fit_scale_address_generator: a cycle-free scan predictor checks every
// output beat, under random config phases, random input gaps and output stalls.
// Depends on bfsa_pkg and the design files only.
module tb_bmp_fit_scale_address_generator;
    import bfsa_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int MAX_SOURCE_DIM = 4096;
    localparam int MAX_BOX_DIM    = 1024;

    typedef struct packed {
        logic        valid_res;
        logic [10:0] screen_x;
        logic [10:0] screen_y;
        logic [31:0] source_offset;
        logic        row_end;
        logic        image_end;
    } t_blit_pixel;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} t_stall_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_start_req = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_valid_res;
    logic [10:0] o_screen_x;
    logic [10:0] o_screen_y;
    logic [31:0] o_source_offset;
    logic        o_row_end;
    logic        o_image_end;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = CFG_DATA_OFFSET;
    logic [31:0] i_cfg_data = '0;

    bmp_fit_scale_address_generator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_start_req     (i_start_req),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_valid_res     (o_valid_res),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y),
        .o_source_offset (o_source_offset),
        .o_row_end       (o_row_end),
        .o_image_end     (o_image_end),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    t_cfg regs = '{RST_DATA_OFFSET, RST_SOURCE_WIDTH, RST_SOURCE_HEIGHT, RST_ROWS_BOTTOM_UP,
                   RST_BOX_LEFT, RST_BOX_TOP, RST_BOX_WIDTH, RST_BOX_HEIGHT};

    int unsigned scan_w = 1, scan_h = 1, org_x = 0, org_y = 0, pitch = 4;
    int unsigned col = 0, row = 0;
    bit          scan_done = 1'b1;

    t_blit_pixel expected_q[$];
    int unsigned fault_count = 0;
    int unsigned beats_sent = 0;
    int unsigned burst_left = 0;
    int unsigned gap_max = 4;
    t_stall_mode stall_mode = STALL_LIGHT;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    int unsigned rx_tick = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_blit_pixel next_pixel(input logic start);
        int unsigned sw, sh, bw, bh, ow, oh, sx, sy;
        t_blit_pixel px;
        px = '0;
        sw = clamp_dim(regs.source_width, MAX_SOURCE_DIM);
        sh = clamp_dim(regs.source_height, MAX_SOURCE_DIM);
        if (start) begin
            bw = clamp_dim(regs.box_width, MAX_BOX_DIM);
            bh = clamp_dim(regs.box_height, MAX_BOX_DIM);
            ow = bw;
            oh = (sh * bw) / sw;
            if (oh > bh) begin
                oh = bh;
                ow = (sw * bh) / sh;
            end
            scan_w = clamp_dim(ow, bw);
            scan_h = clamp_dim(oh, bh);
            org_x = regs.box_left + (bw - scan_w) / 2;
            org_y = regs.box_top + (bh - scan_h) / 2;
            pitch = (sw * 3 + 3) & 32'hFFFF_FFFC;
            col = 0;
            row = 0;
            scan_done = 1'b0;
        end
        if (scan_done) return px;
        sx = (col * sw) / scan_w;
        sy = (row * sh) / scan_h;
        if (regs.rows_bottom_up) sy = sh - 1 - sy;
        px.valid_res = 1'b1;
        px.screen_x = 11'(org_x + col);
        px.screen_y = 11'(org_y + row);
        px.source_offset = regs.data_offset + sy * pitch + sx * 3;
        px.row_end = (col + 1 >= scan_w);
        px.image_end = px.row_end && (row + 1 >= scan_h);
        if (px.row_end) begin
            col = 0;
            row = row + 1;
            if (px.image_end) scan_done = 1'b1;
        end else begin
            col = col + 1;
        end
        return px;
    endfunction

    function automatic t_cfg make_config(input logic [31:0] offset, input logic [12:0] sw,
                                         input logic [12:0] sh, input logic bottom_up,
                                         input logic [9:0] left, input logic [9:0] top,
                                         input logic [10:0] bw, input logic [10:0] bh);
        return '{offset, sw, sh, bottom_up, left, top, bw, bh};
    endfunction

    function automatic logic [12:0] random_source_dim();
        case ($urandom_range(0, 15))
            0: return 13'd0;
            1: return 13'd1;
            2: return 13'(MAX_SOURCE_DIM);
            3: return 13'($urandom_range(MAX_SOURCE_DIM + 1, 8191));
            4, 5: return 13'($urandom_range(1, MAX_SOURCE_DIM));
            default: return 13'($urandom_range(1, 48));
        endcase
    endfunction

    function automatic logic [10:0] random_box_dim();
        case ($urandom_range(0, 19))
            0: return 11'd0;
            1: return 11'(MAX_BOX_DIM);
            2: return 11'($urandom_range(MAX_BOX_DIM + 1, 2047));
            3: return 11'($urandom_range(13, MAX_BOX_DIM));
            default: return 11'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic t_cfg random_config();
        t_cfg c;
        case ($urandom_range(0, 7))
            0: c.data_offset = '0;
            1: c.data_offset = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: c.data_offset = $urandom;
        endcase
        c.source_width = random_source_dim();
        c.source_height = random_source_dim();
        c.rows_bottom_up = 1'($urandom_range(0, 1));
        c.box_left = 10'($urandom_range(0, 1023));
        c.box_top = 10'($urandom_range(0, 1023));
        c.box_width = random_box_dim();
        c.box_height = random_box_dim();
        return c;
    endfunction

    function automatic void shuffle_traffic();
        case ($urandom_range(0, 3))
            0: gap_max = 0;
            1: gap_max = 3;
            2: gap_max = 10;
            default: gap_max = 30;
        endcase
        stall_mode = t_stall_mode'($urandom_range(0, 3));
    endfunction

    task automatic put_reg(input t_cfg_idx idx, input logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        put_reg(CFG_DATA_OFFSET, c.data_offset);
        put_reg(CFG_SOURCE_WIDTH, 32'(c.source_width));
        put_reg(CFG_SOURCE_HEIGHT, 32'(c.source_height));
        put_reg(CFG_ROWS_BOTTOM_UP, 32'(c.rows_bottom_up));
        put_reg(CFG_BOX_LEFT, 32'(c.box_left));
        put_reg(CFG_BOX_TOP, 32'(c.box_top));
        put_reg(CFG_BOX_WIDTH, 32'(c.box_width));
        put_reg(CFG_BOX_HEIGHT, 32'(c.box_height));
        i_cfg_we <= 1'b0;
        regs = c;
    endtask

    task automatic send_beat(input logic start);
        int unsigned pause;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gap_max != 0) begin
                pause = $urandom_range(1, gap_max);
                i_in_valid <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_start_req <= start;
        do @(posedge i_clk); while (o_in_stall);
        expected_q.push_back(next_pixel(start));
        beats_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic report_fault(input string what, input t_blit_pixel want,
                                input t_blit_pixel got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s: expected v=%0d x=%0d y=%0d off=%h re=%0d ie=%0d",
                     what, want.valid_res, want.screen_x, want.screen_y, want.source_offset,
                     want.row_end, want.image_end);
            $display("    got v=%0d x=%0d y=%0d off=%h re=%0d ie=%0d",
                     got.valid_res, got.screen_x, got.screen_y, got.source_offset,
                     got.row_end, got.image_end);
        end
    endtask

    always @(posedge i_clk) begin
        t_blit_pixel got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_valid_res, o_screen_x, o_screen_y, o_source_offset, o_row_end,
                   o_image_end};
            if (expected_q.size() == 0) begin
                report_fault("unexpected beat", '0, got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) report_fault("mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        rx_tick++;
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                STALL_NONE:     i_out_stall <= 1'b0;
                STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: i_out_stall <= ((rx_tick % 9) < 4);
                default:        i_out_stall <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    task automatic test_reset_state();
        send_beat(1'b0);
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b0);
    endtask

    task automatic test_size_extremes();
        drain_results();
        load_config(make_config(32'hFFFF_FFF0, 13'(MAX_SOURCE_DIM), 13'(MAX_SOURCE_DIM), 1'b1,
                                10'd1023, 10'd1023, 11'(MAX_BOX_DIM), 11'(MAX_BOX_DIM)));
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b0);
        drain_results();
        load_config(make_config(32'd0, 13'd0, 13'd8191, 1'b0, 10'd0, 10'd0, 11'd0, 11'd2047));
        send_beat(1'b1);
        send_beat(1'b0);
        drain_results();
        load_config(make_config(32'h8000_0000, 13'd8191, 13'd0, 1'b1, 10'd512, 10'd256,
                                11'd2047, 11'd0));
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b0);
    endtask

    task automatic test_full_scan();
        drain_results();
        load_config(make_config(32'd100, 13'd2, 13'd2, 1'b0, 10'd5, 10'd6, 11'd2, 11'd2));
        send_beat(1'b1);
        send_beat(1'b0);
        drain_results();
        load_config(make_config(32'd200, 13'd3, 13'd2, 1'b1, 10'd5, 10'd6, 11'd2, 11'd2));
        send_beat(1'b0);
        send_beat(1'b0);
        send_beat(1'b0);
    endtask

    task automatic test_random_scans(input int unsigned n_beats);
        int unsigned goal, pixels, total, split, k;
        goal = beats_sent + n_beats;
        while (beats_sent < goal) begin
            drain_results();
            shuffle_traffic();
            load_config(random_config());
            repeat ($urandom_range(1, 4)) begin
                send_beat(1'b1);
                pixels = scan_w * scan_h;
                total = (pixels > 300) ? $urandom_range(5, 40) : pixels + $urandom_range(0, 2);
                if ($urandom_range(0, 9) == 0) total = $urandom_range(0, total);
                split = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total) : total;
                for (k = 0; (k < total) && (beats_sent < goal); k++) begin
                    if (k == split) begin
                        drain_results();
                        load_config(random_config());
                    end
                    send_beat(1'b0);
                end
            end
        end
    endtask

    task automatic test_backpressure();
        drain_results();
        load_config(make_config($urandom, 13'd40, 13'd30, 1'b1, 10'd100, 10'd200, 11'd12,
                                11'd12));
        gap_max = 0;
        stall_mode = STALL_NONE;
        hold_request = 300;
        send_beat(1'b1);
        repeat (60) send_beat(1'b0);
        drain_results();
        stall_mode = STALL_PERIODIC;
        repeat (60) send_beat(1'b0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_size_extremes();
        test_full_scan();
        test_random_scans(1710);
        test_backpressure();
        drain_results();
        repeat (100) @(posedge i_clk);
        if (expected_q.size() != 0) fault_count++;
        if (fault_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 2_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
